// ----- src/lkc_pkg.sv -----
// shared types and constants for the keyed lru cache lookup
`default_nettype none

package lkc_pkg;

	localparam int KEY_W        = 32;
	localparam int SLOT_W       = 4;
	localparam int DEF_ENTRIES  = 16;
	localparam int DEF_AGE_BITS = 32;

	// request transaction
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             load_ok;
		logic             default_ok;
	} req_t;

	// response transaction
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic              was_hit;
		logic              fell_back;
	} rsp_t;

endpackage

`default_nettype wire

// ----- src/lkc_mem.sv -----
// key and age storage with one write port and one registered read port
`default_nettype none

module lkc_mem
	import lkc_pkg::*;
#(
	parameter int ENTRIES  = DEF_ENTRIES,
	parameter int AGE_BITS = DEF_AGE_BITS,
	localparam int IW      = $clog2(ENTRIES)
) (
	input  wire logic                clk,
	input  wire logic [IW-1:0]       rd_addr,
	output logic      [KEY_W-1:0]    rd_key,
	output logic      [AGE_BITS-1:0] rd_age,
	input  wire logic                we_key,
	input  wire logic                we_age,
	input  wire logic [IW-1:0]       wr_addr,
	input  wire logic [KEY_W-1:0]    wr_key,
	input  wire logic [AGE_BITS-1:0] wr_age
);

	logic [KEY_W-1:0]    key_mem [ENTRIES];
	logic [AGE_BITS-1:0] age_mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (we_key) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (we_age) begin
			age_mem[wr_addr] <= wr_age;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_age <= age_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- src/lru_keyed_cache_lookup.sv -----
// Fully associative keyed cache with timestamp lru replacement. A request is
// taken while req_stall is low and yields exactly one response. Each lookup pass
// reads the key/age store one entry per cycle through its single read port and
// checks key match, first free entry and smallest age with one shared compare
// unit. A request answers after one pass, or after a second pass when a failed
// load retries with default_key.
// req_stall stays high from acceptance until the response is in the output
// register. The output register lets a request be accepted while the previous
// response still waits. Configuration writes are always ready.
`default_nettype none

module lru_keyed_cache_lookup
	import lkc_pkg::*;
#(
	parameter int ENTRIES  = DEF_ENTRIES,
	parameter int AGE_BITS = DEF_AGE_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [KEY_W-1:0] cfg_data
);

	localparam int IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_OUT    = 2'd3;

	logic [1:0]          state_q;
	logic [KEY_W-1:0]    default_key_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [AGE_BITS-1:0] tick_q;

	logic [KEY_W-1:0]    lookup_key_q;
	logic                ok_q;
	logic                dok_q;
	logic                fb_q;

	logic [IW-1:0]       scan_q;
	logic                issue_done_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic [KEY_W-1:0]    rd_key_s1;
	logic [AGE_BITS-1:0] rd_age_s1;

	logic                hit_found_q;
	logic [IW-1:0]       hit_idx_q;
	logic                free_found_q;
	logic [IW-1:0]       free_idx_q;
	logic [AGE_BITS-1:0] min_age_q;
	logic [IW-1:0]       min_idx_q;

	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                we_key;
	logic                we_age;
	logic [IW-1:0]       wr_addr;
	logic [IW-1:0]       victim;
	logic [AGE_BITS-1:0] tick_next;
	logic                key_match;
	logic                age_lower;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// shared compare unit and decision terms
	assign key_match = valid_q[rd_idx_s1] && (rd_key_s1 == lookup_key_q);
	assign age_lower = (rd_idx_s1 == '0) || (rd_age_s1 < min_age_q);
	assign tick_next = tick_q + AGE_BITS'(1);
	assign victim    = free_found_q ? free_idx_q : min_idx_q;

	// store write controls, used only in the decide step
	always_comb begin
		we_key  = 1'b0;
		we_age  = 1'b0;
		wr_addr = victim;
		if (state_q == ST_DECIDE) begin
			if (hit_found_q) begin
				we_age  = 1'b1;
				wr_addr = hit_idx_q;
			end else if (ok_q) begin
				we_key = 1'b1;
				we_age = 1'b1;
			end
		end
	end

	lkc_mem #(
		.ENTRIES  (ENTRIES),
		.AGE_BITS (AGE_BITS)
	) u_mem (
		.clk     (clk),
		.rd_addr (scan_q),
		.rd_key  (rd_key_s1),
		.rd_age  (rd_age_s1),
		.we_key  (we_key),
		.we_age  (we_age),
		.wr_addr (wr_addr),
		.wr_key  (lookup_key_q),
		.wr_age  (tick_next)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			default_key_q <= cfg_data;
		end
	end

	// sequencer and scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			tick_q       <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			fb_q         <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// output register drains independently
			if (rsp_valid_q && !rsp_stall && (state_q != ST_OUT)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						lookup_key_q <= req.key;
						ok_q         <= req.load_ok;
						dok_q        <= req.default_ok;
						fb_q         <= 1'b0;
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle
					rd_vld_s1 <= !issue_done_q;
					rd_idx_s1 <= scan_q;
					if (!issue_done_q) begin
						issue_done_q <= (scan_q == LAST_IDX);
						if (scan_q != LAST_IDX) begin
							scan_q <= scan_q + IW'(1);
						end
					end
					// compare the entry read last cycle
					if (rd_vld_s1) begin
						if (key_match && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= rd_idx_s1;
						end
						if (!valid_q[rd_idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= rd_idx_s1;
						end
						if (age_lower) begin
							min_age_q <= rd_age_s1;
							min_idx_q <= rd_idx_s1;
						end
						if (rd_idx_s1 == LAST_IDX) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					priority if (hit_found_q) begin
						state_q         <= ST_OUT;
						tick_q          <= tick_next;
						res_q.found     <= 1'b1;
						res_q.slot      <= SLOT_W'(hit_idx_q);
						res_q.was_hit   <= 1'b1;
						res_q.fell_back <= fb_q;
					end else if (ok_q) begin
						state_q         <= ST_OUT;
						tick_q          <= tick_next;
						valid_q[victim] <= 1'b1;
						res_q.found     <= 1'b1;
						res_q.slot      <= SLOT_W'(victim);
						res_q.was_hit   <= 1'b0;
						res_q.fell_back <= fb_q;
					end else if (!fb_q && (lookup_key_q != default_key_q)) begin
						// retry the whole lookup with the default key
						fb_q         <= 1'b1;
						lookup_key_q <= default_key_q;
						ok_q         <= dok_q;
						scan_q       <= '0;
						issue_done_q <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
						res_q   <= '0;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response payload register
	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

endmodule

`default_nettype wire

// ----- sim/lru_keyed_cache_lookup_test.sv -----
// testbench for the keyed lru cache lookup: directed table, random traffic, lookup predictor
`timescale 1ns / 100ps

module lru_keyed_cache_lookup_test;
	import lkc_pkg::*;

	localparam int ENTRIES     = DEF_ENTRIES;
	localparam int AGE_BITS    = DEF_AGE_BITS;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int SHOW_MAX    = 10;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [KEY_W-1:0] cfg_data;

	// mirror of the cache contents and the default key
	bit                  cache_valid [ENTRIES];
	logic [KEY_W-1:0]    cache_key   [ENTRIES];
	logic [AGE_BITS-1:0] cache_age   [ENTRIES];
	logic [AGE_BITS-1:0] cache_tick;
	logic [KEY_W-1:0]    dflt_key;

	rsp_t             awaited_rsp [$];
	dir_row_t         directed_reqs [$];
	logic [KEY_W-1:0] key_pool [64];
	int               burst_left;
	int               mismatches;
	int               idle_cycles;
	int               hold_asks;
	int               holds_done;

	lru_keyed_cache_lookup #(
		.ENTRIES (ENTRIES),
		.AGE_BITS(AGE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one pass over the cache: hit, else fill the free or oldest entry if the load works
	function automatic bit lookup_pass(input logic [KEY_W-1:0] k, input bit ok,
			output logic [SLOT_W-1:0] where, output bit hit);
		int victim;
		bit have_free;
		victim    = 0;
		have_free = 1'b0;
		hit       = 1'b0;
		where     = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i] && cache_key[i] == k) begin
				cache_tick   = cache_tick + AGE_BITS'(1);
				cache_age[i] = cache_tick;
				where        = SLOT_W'(i);
				hit          = 1'b1;
				return 1'b1;
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (!have_free && !cache_valid[i]) begin
				victim    = i;
				have_free = 1'b1;
			end
		end
		if (!have_free) begin
			for (int i = 1; i < ENTRIES; i++)
				if (cache_age[i] < cache_age[victim])
					victim = i;
		end
		if (!ok)
			return 1'b0;
		cache_tick          = cache_tick + AGE_BITS'(1);
		cache_valid[victim] = 1'b1;
		cache_key[victim]   = k;
		cache_age[victim]   = cache_tick;
		where               = SLOT_W'(victim);
		return 1'b1;
	endfunction

	// full lookup with a single retry on the default key
	function automatic rsp_t predict_lookup(input req_t r);
		rsp_t              res;
		logic [SLOT_W-1:0] where;
		bit                hit;
		bit                fb;
		bit                got;
		fb  = 1'b0;
		got = lookup_pass(r.key, r.load_ok, where, hit);
		if (!got && r.key != dflt_key) begin
			fb  = 1'b1;
			got = lookup_pass(dflt_key, r.default_ok, where, hit);
		end
		res = '0;
		if (got) begin
			res.found     = 1'b1;
			res.slot      = where;
			res.was_hit   = hit;
			res.fell_back = fb;
		end
		return res;
	endfunction

	task automatic add_row(input logic [KEY_W-1:0] k, input bit lok, input bit dok,
			input bit typed, input rsp_t want);
		dir_row_t row;
		row.item  = '{k, lok, dok};
		row.typed = typed;
		row.want  = want;
		directed_reqs.push_back(row);
	endtask

	// offer one request transaction, with bursts and random gaps in front
	task automatic send_req(input req_t item, input bit typed, input rsp_t want);
		int   gap;
		rsp_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		burst_left--;
		predicted = predict_lookup(item);
		awaited_rsp.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain;
		req_valid  <= 1'b0;
		burst_left = 0;
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_default_key(input logic [KEY_W-1:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dflt_key  = v;
	endtask

	// main sequence
	initial begin
		req_t             item;
		logic [KEY_W-1:0] phase_key;
		int               pool_n;
		int               roll;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		hold_asks  = 0;
		burst_left = 0;
		cache_tick = '0;
		dflt_key   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_key[i]   = '0;
			cache_age[i]   = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, default key still at reset value zero
		add_row(32'h0000_0000, 1'b0, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0});
		add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0});
		add_row(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b0, 1'b1});
		add_row(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 1'b0});
		add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b1, 1'b0});
		add_row(32'h0000_0000, 1'b0, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, 1'b0});
		add_row(32'h0000_0005, 1'b0, 1'b1, 1'b1, '{1'b1, 4'd0, 1'b1, 1'b1});
		add_row(32'h8000_0000, 1'b1, 1'b0, 1'b1, '{1'b1, 4'd2, 1'b0, 1'b0});
		// fill the rest of the cache up to the last slot
		for (int i = 0; i < 13; i++)
			add_row(32'h0000_0100 + i, 1'b1, 1'b0, 1'b0, '0);
		// eviction of the oldest entry, then fallbacks on hits and misses
		add_row(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, '0);
		add_row(32'h0000_1234, 1'b0, 1'b0, 1'b0, '0);
		add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0);
		add_row(32'h0000_0000, 1'b0, 1'b1, 1'b0, '0);
		foreach (directed_reqs[n])
			send_req(directed_reqs[n].item, directed_reqs[n].typed, directed_reqs[n].want);
		drain();

		// random phases, each with its own default key and key pool size
		for (int p = 0; p < 3; p++) begin
			phase_key = (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? KEY_W'($urandom) : 32'h0;
			pool_n    = (p == 0) ? 12 : (p == 1) ? 24 : 40;
			write_default_key(phase_key);
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = $urandom;
			for (int n = 0; n < 560; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					item.key = dflt_key;
				else if (roll < 20)
					item.key = $urandom;
				else
					item.key = key_pool[$urandom_range(0, pool_n - 1)];
				item.load_ok    = ($urandom_range(0, 99) < 80);
				item.default_ok = 1'($urandom_range(0, 1));
				// long response hold-off while requests keep coming
				if (p == 1 && n == 200)
					hold_asks <= hold_asks + 1;
				send_req(item, 1'b0, '0);
			end
			drain();
		end

		repeat (2 * ENTRIES + 10) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// response side stall pattern, with a long hold-off on request
	initial begin
		int mode_left;
		int stall_pct;
		rsp_stall  = 1'b0;
		holds_done = 0;
		mode_left  = 0;
		stall_pct  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 60;
						default: stall_pct = 90;
					endcase
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				rsp_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// compare each response transaction with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("unexpected response found=%0d slot=%0d hit=%0d fb=%0d",
						rsp.found, rsp.slot, rsp.was_hit, rsp.fell_back);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.found !== want.found || rsp.slot !== want.slot ||
						rsp.was_hit !== want.was_hit || rsp.fell_back !== want.fell_back) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("mismatch found/slot/hit/fb: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.found, want.slot, want.was_hit, want.fell_back,
							rsp.found, rsp.slot, rsp.was_hit, rsp.fell_back);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		mismatches  = 0;
		idle_cycles = 0;
	end

endmodule

// ----- filelist.f -----
src/lkc_pkg.sv
src/lkc_mem.sv
src/lru_keyed_cache_lookup.sv
sim/lru_keyed_cache_lookup_test.sv
